/* rtl/lfu_pkg.sv */
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared constants and types for the LFU key-value table: table size, index
// widths, the scan token that runs down the cell chain and the update beat.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W   = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int CNT_W   = 32;
  localparam int TCH_W   = 64;
  localparam int CAP_W   = 5;
  localparam int OUT_OCC_W = 5;

  // command codes
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  // scan token, one hop per cell per cycle
  typedef struct packed {
    logic             vld;
    logic [KEY_W-1:0] key;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic [VAL_W-1:0] hit_val;
    logic             best_vld;
    logic [IDX_W-1:0] best_idx;
    logic [CNT_W-1:0] best_cnt;
    logic [TCH_W-1:0] best_touch;
    logic [KEY_W-1:0] best_key;
    logic             free_vld;
    logic [IDX_W-1:0] free_idx;
  } scan_t;

  // broadcast write to the cells
  typedef struct packed {
    logic             touch;
    logic             insert;
    logic             wr_val;
    logic [IDX_W-1:0] idx;
    logic             evict;
    logic [IDX_W-1:0] ev_idx;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
    logic [TCH_W-1:0] stamp;
  } upd_t;

endpackage

/* rtl/lfu_cell.sv */
// ----------------------------------------------------------------------------
// lfu_cell
// One table entry. Folds its entry into the passing scan token (key match,
// first free slot, eviction candidate) and applies broadcast updates.
// ----------------------------------------------------------------------------
module lfu_cell import lfu_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] my_idx,
  input  scan_t            tok_in,
  output scan_t            tok_out,
  input  upd_t             upd
);

  logic             valid;
  logic [KEY_W-1:0] key;
  logic [VAL_W-1:0] val;
  logic [CNT_W-1:0] cnt;
  logic [TCH_W-1:0] touch;
  scan_t            tok_next;

  // fold own entry into the token
  always_comb begin
    tok_next = tok_in;
    if (!tok_in.hit && valid && key == tok_in.key) begin
      tok_next.hit     = 1'b1;
      tok_next.hit_idx = my_idx;
      tok_next.hit_val = val;
    end
    if (!tok_in.free_vld && !valid) begin
      tok_next.free_vld = 1'b1;
      tok_next.free_idx = my_idx;
    end
    if (valid && (!tok_in.best_vld || cnt < tok_in.best_cnt ||
                  (cnt == tok_in.best_cnt && touch < tok_in.best_touch))) begin
      tok_next.best_vld   = 1'b1;
      tok_next.best_idx   = my_idx;
      tok_next.best_cnt   = cnt;
      tok_next.best_touch = touch;
      tok_next.best_key   = key;
    end
  end

  // token hop register
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.vld <= 1'b0;
    end else begin
      tok_out.vld <= tok_next.vld;
    end
    tok_out.key        <= tok_next.key;
    tok_out.hit        <= tok_next.hit;
    tok_out.hit_idx    <= tok_next.hit_idx;
    tok_out.hit_val    <= tok_next.hit_val;
    tok_out.best_vld   <= tok_next.best_vld;
    tok_out.best_idx   <= tok_next.best_idx;
    tok_out.best_cnt   <= tok_next.best_cnt;
    tok_out.best_touch <= tok_next.best_touch;
    tok_out.best_key   <= tok_next.best_key;
    tok_out.free_vld   <= tok_next.free_vld;
    tok_out.free_idx   <= tok_next.free_idx;
  end

  // entry valid: eviction first, insert wins
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      if (upd.evict && upd.ev_idx == my_idx) valid <= 1'b0;
      if (upd.insert && upd.idx == my_idx) valid <= 1'b1;
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    if (upd.idx == my_idx) begin
      if (upd.insert) begin
        key   <= upd.key;
        val   <= upd.val;
        cnt   <= CNT_W'(1);
        touch <= upd.stamp;
      end else if (upd.touch) begin
        if (upd.wr_val) val <= upd.val;
        if (cnt != {CNT_W{1'b1}}) cnt <= cnt + CNT_W'(1);
        touch <= upd.stamp;
      end
    end
  end

endmodule

/* rtl/lfu_cache_table_core.sv */
// ----------------------------------------------------------------------------
// lfu_cache_table_core
// Fully associative key-value table with least-frequently-used replacement
// and least-recently-touched tie break, built as a chain of entry cells.
// ----------------------------------------------------------------------------
// Usage:
//   s_* stream carries one get or put per beat: tuser is the command,
//   tdata holds key and value. m_* stream returns one result beat per item.
//   cfg_* writes the capacity register; it is always ready and must only be
//   written while the block is idle.
// Timing:
//   an accepted item sends a scan token down the ENTRIES cells, one cell per
//   cycle; the cycle after it leaves the last cell the table is updated and
//   the result is registered. The next item is taken only once the token of
//   the last one has left the chain and the holding register is empty.
// Stalls:
//   a result that is not taken waits in the output register, a second one
//   in a holding register; s_tready stays low while that register is full.
// Reset:
//   rst empties the table, clears the touch clock and sets capacity to 16.
//   No clearing pass is needed.
// ----------------------------------------------------------------------------
module lfu_cache_table_core import lfu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [63:0]          s_tdata,   // key[31:0], value[63:32]
  input  logic [0:0]           s_tuser,   // command[0]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [71:0]          m_tdata,   // hit[0], read_value[32:1], evicted[33],
                                          // evicted_key[65:34], occupancy[70:66]
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CAP_W-1:0]     cfg_data
);

  logic [CAP_W-1:0] capacity;
  logic             busy;
  logic             cmd;
  logic [VAL_W-1:0] val_in;
  logic [TCH_W-1:0] touch_clock;
  logic [OCC_W-1:0] valid_count;
  logic [OCC_W-1:0] valid_count_next;
  logic             pend_valid;
  logic [71:0]      pend_data;
  logic [71:0]      res;
  scan_t            tok_head;
  scan_t            chain [ENTRIES+1];
  scan_t            tok_end;
  upd_t             upd;
  logic [OCC_W-1:0] cap_eff;
  logic             accept;
  logic             done;
  logic             ev;
  logic             ins;
  logic [IDX_W-1:0] dst;

  assign cfg_ready = 1'b1;
  assign s_tready  = !busy && !pend_valid;
  assign accept    = s_tvalid && s_tready;

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_W'(16);
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  assign cap_eff = ({27'd0, capacity} > 32'(ENTRIES)) ? OCC_W'(ENTRIES) : OCC_W'(capacity);

  // token entering the first cell
  always_comb begin
    tok_head          = '0;
    tok_head.vld      = accept;
    tok_head.key      = s_tdata[31:0];
  end

  assign chain[0] = tok_head;

  // cell chain
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lfu_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .my_idx  (IDX_W'(i)),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1]),
      .upd     (upd)
    );
  end

  assign tok_end = chain[ENTRIES];
  assign done    = tok_end.vld;

  // decision at the end of the chain
  always_comb begin
    upd              = '0;
    upd.key          = tok_end.key;
    upd.val          = val_in;
    upd.stamp        = touch_clock + TCH_W'(1);
    ev               = 1'b0;
    ins              = 1'b0;
    dst              = tok_end.free_idx;
    valid_count_next = valid_count;
    res              = '0;
    res[0]           = tok_end.hit;
    if (done) begin
      if (cmd == CMD_GET) begin
        if (tok_end.hit) begin
          upd.touch   = 1'b1;
          upd.idx     = tok_end.hit_idx;
          res[32:1]   = tok_end.hit_val;
        end
      end else if (cap_eff != '0) begin
        if (tok_end.hit) begin
          upd.touch  = 1'b1;
          upd.wr_val = 1'b1;
          upd.idx    = tok_end.hit_idx;
        end else begin
          ev = (valid_count >= cap_eff) && tok_end.best_vld;
          if (ev) begin
            dst = (tok_end.free_vld && tok_end.free_idx < tok_end.best_idx) ?
                  tok_end.free_idx : tok_end.best_idx;
          end
          ins        = ev || tok_end.free_vld;
          upd.evict  = ev;
          upd.ev_idx = tok_end.best_idx;
          upd.insert = ins;
          upd.idx    = dst;
          valid_count_next = valid_count - OCC_W'(ev) + OCC_W'(ins);
        end
      end
    end
    res[33]    = ev;
    res[65:34] = ev ? tok_end.best_key : '0;
    res[70:66] = OUT_OCC_W'(valid_count_next);
  end

  // item control and table counters
  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      touch_clock <= '0;
      valid_count <= '0;
    end else begin
      if (accept) busy <= 1'b1;
      else if (done) busy <= 1'b0;
      if (upd.touch || upd.insert) touch_clock <= touch_clock + TCH_W'(1);
      valid_count <= valid_count_next;
    end
  end

  // item payload held during the scan
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd    <= s_tuser[0];
      val_in <= s_tdata[63:32];
    end
  end

  // output register and holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (done) begin
        if (!m_tvalid || m_tready) m_tvalid <= 1'b1;
        else pend_valid <= 1'b1;
      end else if (pend_valid && (!m_tvalid || m_tready)) begin
        m_tvalid   <= 1'b1;
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      if (!m_tvalid || m_tready) m_tdata <= res;
      else pend_data <= res;
    end else if (pend_valid && (!m_tvalid || m_tready)) begin
      m_tdata <= pend_data;
    end
  end

  // checks
  a_end_busy : assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("scan token left the chain with no item in flight");
  a_occ_max : assert property (@(posedge clk) disable iff (rst)
    32'(valid_count) <= 32'(ENTRIES))
    else $error("occupancy above table size");
  a_pend_out : assert property (@(posedge clk) disable iff (rst) pend_valid |-> m_tvalid)
    else $error("holding register full while output register empty");
  a_ev_put : assert property (@(posedge clk) disable iff (rst) ev |-> cmd == CMD_PUT)
    else $error("eviction on a get");

endmodule

/* verif/lfu_cache_table_checker.sv */
// ----------------------------------------------------------------------------
// lfu_cache_table_checker
// Watches the item, result and capacity channels of the LFU table, keeps a
// shadow table with the same replacement policy and compares every result
// beat with the expected one, oldest first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfu_cache_table_checker import lfu_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [63:0]      s_tdata,
  input  logic [0:0]       s_tuser,
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [71:0]      m_tdata,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data,
  output int               fail_count,
  output int               pending
);

  typedef struct packed {
    logic [OUT_OCC_W-1:0] occupancy;
    logic [KEY_W-1:0]     evicted_key;
    logic                 evicted;
    logic [VAL_W-1:0]     read_value;
    logic                 hit;
  } lookup_result_t;

  // shadow table
  logic             sh_valid [ENTRIES];
  logic [KEY_W-1:0] sh_key   [ENTRIES];
  logic [VAL_W-1:0] sh_val   [ENTRIES];
  logic [CNT_W-1:0] sh_count [ENTRIES];
  logic [TCH_W-1:0] sh_touch [ENTRIES];
  logic [TCH_W-1:0] sh_clock;
  int               sh_used;
  logic [CAP_W-1:0] sh_capacity;

  lookup_result_t expected_results[$];

  assign pending = expected_results.size();

  task automatic report_mismatch(input string what, input logic [KEY_W-1:0] got,
                                 input logic [KEY_W-1:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic void bump_entry(input int i);
    if (sh_count[i] != '1) sh_count[i]++;
    sh_clock++;
    sh_touch[i] = sh_clock;
  endfunction

  // apply one get or put to the shadow table and return the result
  function automatic lookup_result_t predict_lookup(input logic cmd,
                                                    input logic [KEY_W-1:0] k,
                                                    input logic [VAL_W-1:0] v);
    lookup_result_t r;
    int slot, victim, dst, cap;
    r = '0;
    slot = -1;
    victim = -1;
    dst = -1;
    cap = (sh_capacity > ENTRIES) ? ENTRIES : sh_capacity;
    for (int i = 0; i < ENTRIES; i++)
      if (slot < 0 && sh_valid[i] && sh_key[i] == k) slot = i;
    r.hit = (slot >= 0);
    if (cmd == CMD_GET) begin
      if (slot >= 0) begin
        bump_entry(slot);
        r.read_value = sh_val[slot];
      end
    end else if (cap != 0) begin
      if (slot >= 0) begin
        sh_val[slot] = v;
        bump_entry(slot);
      end else begin
        if (sh_used >= cap) begin
          for (int i = 0; i < ENTRIES; i++)
            if (sh_valid[i] && (victim < 0 || sh_count[i] < sh_count[victim] ||
                (sh_count[i] == sh_count[victim] && sh_touch[i] < sh_touch[victim])))
              victim = i;
          if (victim >= 0) begin
            r.evicted = 1'b1;
            r.evicted_key = sh_key[victim];
            sh_valid[victim] = 1'b0;
            sh_used--;
          end
        end
        for (int i = 0; i < ENTRIES; i++)
          if (dst < 0 && !sh_valid[i]) dst = i;
        if (dst >= 0) begin
          sh_valid[dst] = 1'b1;
          sh_key[dst] = k;
          sh_val[dst] = v;
          sh_count[dst] = 1;
          sh_clock++;
          sh_touch[dst] = sh_clock;
          sh_used++;
        end
      end
    end
    r.occupancy = sh_used[OUT_OCC_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    lookup_result_t got, want;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) sh_valid[i] = 1'b0;
      sh_clock = '0;
      sh_used = 0;
      sh_capacity = 5'd16;
      fail_count = 0;
      expected_results.delete();
    end else begin
      // capacity write
      if (cfg_valid && cfg_ready) sh_capacity = cfg_data;
      // input beat
      if (s_tvalid && s_tready)
        expected_results.insert(expected_results.size(),
                                predict_lookup(s_tuser[0], s_tdata[31:0],
                                               s_tdata[63:32]));
      // result beat
      if (m_tvalid && m_tready) begin
        got = m_tdata[70:0];
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result beat", got.evicted_key, '0);
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (got.hit != want.hit) report_mismatch("hit", got.hit, want.hit);
          if (got.read_value != want.read_value)
            report_mismatch("read_value", got.read_value, want.read_value);
          if (got.evicted != want.evicted)
            report_mismatch("evicted", got.evicted, want.evicted);
          if (got.evicted_key != want.evicted_key)
            report_mismatch("evicted_key", got.evicted_key, want.evicted_key);
          if (got.occupancy != want.occupancy)
            report_mismatch("occupancy", got.occupancy, want.occupancy);
        end
      end
    end
  end

endmodule

/* verif/lfu_cache_table_core_tb.sv */
// ----------------------------------------------------------------------------
// lfu_cache_table_core_tb
// Drives gets and puts over a small key pool at several capacities, with
// random idle bursts on both streams; the checker does the comparison.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfu_cache_table_core_tb;
  import lfu_pkg::*;

  localparam int LATENCY = ENTRIES + 4;
  localparam int WATCHDOG_LIMIT = 5000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [63:0]      s_tdata = '0;
  logic [0:0]       s_tuser = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [71:0]      m_tdata;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data = '0;
  int               fail_count;
  int               pending;
  int               idle_cycles = 0;
  bit               calm = 1'b0;
  logic [31:0]      key_pool [8];

  always #4 clk = ~clk;

  lfu_cache_table_core u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  lfu_cache_table_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  // watchdog on cycles with no beat anywhere
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("lfu_cache_table_core regression: fail");
      $finish;
    end
  end

  // result side stall bursts
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        n = $urandom_range(1, 15);
        repeat (n - 1) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // valid stays high after the beat until the next item or an idle gap
  task automatic send_item(input logic cmd, input logic [31:0] k, input logic [31:0] v);
    int n;
    if (!calm && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 15);
      s_tvalid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {v, k};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly keys from a small pool so hits and evictions happen often
  task automatic random_items(input int count);
    logic [31:0] k;
    for (int i = 0; i < count; i++) begin
      k = ($urandom_range(0, 4) == 0) ? $urandom() : key_pool[$urandom_range(0, 7)];
      send_item(1'($urandom_range(0, 1)), k, $urandom());
    end
  endtask

  initial begin
    key_pool = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h1, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234};
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // directed: miss on an empty table, fill, hit, update, then overflow with ties
    send_item(CMD_GET, 32'h0, 32'hFFFF_FFFF);
    for (int i = 0; i < 8; i++) send_item(CMD_PUT, key_pool[i], ~key_pool[i]);
    send_item(CMD_GET, 32'hFFFF_FFFF, 32'h0);
    send_item(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(CMD_GET, 32'h8000_0000, 32'h0);
    for (int i = 0; i < 10; i++) send_item(CMD_PUT, 32'h100 + i, i);

    // lowered capacity below occupancy, then zero, above table size, one
    write_capacity(5'd3);
    send_item(CMD_PUT, 32'hDEAD_BEEF, 32'h1);
    send_item(CMD_GET, 32'hDEAD_BEEF, 32'h0);
    write_capacity(5'd0);
    send_item(CMD_PUT, 32'hCAFE_0000, 32'h2);
    send_item(CMD_GET, 32'hDEAD_BEEF, 32'h0);

    write_capacity(5'd31);
    random_items(120);
    write_capacity(5'd1);
    random_items(60);
    write_capacity(5'd4);
    random_items(120);
    write_capacity(5'd0);
    random_items(20);
    write_capacity(5'd16);
    random_items(120);
    calm = 1'b1;
    random_items(40);
    s_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
    if (fail_count == 0)
      $display("lfu_cache_table_core regression: pass");
    else
      $display("lfu_cache_table_core regression: fail");
    $finish;
  end

endmodule
